[design/dpsr_pkg.sv]
// ----------------------------------------------------------------------------
// Digital pad serial responder package
// Shared constants and types for the pad responder.
// ----------------------------------------------------------------------------
`default_nettype none

package dpsr_pkg;

  localparam int unsigned POS_W     = 3;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned BTN_W     = 16;
  localparam int unsigned BTN_IDX_W = 4;

  // Exchange sequence positions
  localparam logic [POS_W-1:0] POS_SELECT  = 3'd0;
  localparam logic [POS_W-1:0] POS_COMMAND = 3'd1;
  localparam logic [POS_W-1:0] POS_ID_HI   = 3'd2;
  localparam logic [POS_W-1:0] POS_BTN_LO  = 3'd3;
  localparam logic [POS_W-1:0] POS_BTN_HI  = 3'd4;

  // Link bytes
  localparam logic [BYTE_W-1:0] SEL_BYTE  = 8'h01;
  localparam logic [BYTE_W-1:0] CMD_BYTE  = 8'h42;
  localparam logic [BYTE_W-1:0] ID_LO     = 8'h41;
  localparam logic [BYTE_W-1:0] ID_HI     = 8'h5A;
  localparam logic [BYTE_W-1:0] IDLE_BYTE = 8'hFF;

  // Request kinds
  localparam logic REQ_EXCHANGE = 1'b0;
  localparam logic REQ_BUTTON   = 1'b1;

  localparam logic [BTN_W-1:0] LEVELS_RESET = 16'hFFFF;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [BTN_W-1:0] levels;
    logic [BTN_W-1:0] pending;
  } pad_state_t;

  typedef struct packed {
    logic                 req_type;
    logic [BYTE_W-1:0]    host_byte;
    logic [BTN_IDX_W-1:0] button_number;
    logic                 is_pressed;
  } pad_req_t;

endpackage

`default_nettype wire

[design/dpsr_core.sv]
// ----------------------------------------------------------------------------
// Pad responder step logic
// Combinational update of the pad state for one transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module dpsr_core (
  input  wire dpsr_pkg::pad_state_t      cur,
  input  wire dpsr_pkg::pad_req_t        req,
  output dpsr_pkg::pad_state_t           nxt,
  output logic [dpsr_pkg::BYTE_W-1:0]    reply,
  output logic                           has_reply
);

  logic [dpsr_pkg::BTN_W-1:0] bit_mask;

  assign bit_mask = dpsr_pkg::BTN_W'(1) << req.button_number;

  always_comb begin
    nxt       = cur;
    reply     = dpsr_pkg::IDLE_BYTE;
    has_reply = 1'b0;
    if (req.req_type == dpsr_pkg::REQ_BUTTON) begin
      // press lands at once; release only marks, merged after the next read
      if (req.is_pressed) begin
        nxt.levels = cur.levels & ~bit_mask;
      end else begin
        nxt.pending = cur.pending | bit_mask;
      end
    end else begin
      has_reply = 1'b1;
      case (cur.pos)
        dpsr_pkg::POS_SELECT: begin
          if (req.host_byte == dpsr_pkg::SEL_BYTE) begin
            nxt.pos = dpsr_pkg::POS_COMMAND;
          end
        end
        dpsr_pkg::POS_COMMAND: begin
          if (req.host_byte == dpsr_pkg::CMD_BYTE) begin
            nxt.pos = dpsr_pkg::POS_ID_HI;
            reply   = dpsr_pkg::ID_LO;
          end else begin
            nxt.pos = dpsr_pkg::POS_SELECT;
          end
        end
        dpsr_pkg::POS_ID_HI: begin
          nxt.pos = dpsr_pkg::POS_BTN_LO;
          reply   = dpsr_pkg::ID_HI;
        end
        dpsr_pkg::POS_BTN_LO: begin
          nxt.pos           = dpsr_pkg::POS_BTN_HI;
          reply             = cur.levels[7:0];
          nxt.levels[7:0]   = cur.levels[7:0] | cur.pending[7:0];
          nxt.pending[7:0]  = '0;
        end
        dpsr_pkg::POS_BTN_HI: begin
          nxt.pos           = dpsr_pkg::POS_SELECT;
          reply             = cur.levels[15:8];
          nxt.levels[15:8]  = cur.levels[15:8] | cur.pending[15:8];
          nxt.pending[15:8] = '0;
        end
        default: begin
          nxt.pos = dpsr_pkg::POS_SELECT;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[design/digital_pad_serial_responder.sv]
// ----------------------------------------------------------------------------
// Digital pad serial responder
// Pad side of a byte-exchange serial link with button event tracking.
// ----------------------------------------------------------------------------
// Takes one transaction per clock when not stalled: each is either a host
// byte exchange or a button event. A transaction is captured in an input
// register, then the step logic updates the pad state and, for an
// exchange, loads the reply into the output register, from which it is
// offered to the receiver. Button events produce no reply and never wait
// for the output side. The input stalls only when an exchange sits in the
// input register while the output register holds a reply that is itself
// stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module digital_pad_serial_responder (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire                               in_req_type,
  input  wire  [dpsr_pkg::BYTE_W-1:0]       in_host_byte,
  input  wire  [dpsr_pkg::BTN_IDX_W-1:0]    in_button_number,
  input  wire                               in_is_pressed,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic [dpsr_pkg::BYTE_W-1:0]       out_reply_byte
);

  // Input register stage
  logic                 s1_valid_r;
  dpsr_pkg::pad_req_t   s1_req_r;

  // Pad state and output register
  dpsr_pkg::pad_state_t state_r;
  dpsr_pkg::pad_state_t state_nxt;
  logic                 out_valid_r;
  logic [dpsr_pkg::BYTE_W-1:0] out_reply_r;
  logic [dpsr_pkg::BYTE_W-1:0] reply_nxt;
  logic                 has_reply;

  logic out_free;
  logic s1_fire;
  logic in_fire;

  dpsr_core u_core (
    .cur       (state_r),
    .req       (s1_req_r),
    .nxt       (state_nxt),
    .reply     (reply_nxt),
    .has_reply (has_reply)
  );

  // Output register can take a reply when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;
  // Button events advance regardless of the output side.
  assign s1_fire  = s1_valid_r && (s1_req_r.req_type == dpsr_pkg::REQ_BUTTON || out_free);
  assign in_stall = s1_valid_r && !s1_fire;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Capture payload on accept; hold otherwise.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r.req_type      <= in_req_type;
      s1_req_r.host_byte     <= in_host_byte;
      s1_req_r.button_number <= in_button_number;
      s1_req_r.is_pressed    <= in_is_pressed;
    end
  end

  // Advance pad state with each processed transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.pos     <= dpsr_pkg::POS_SELECT;
      state_r.levels  <= dpsr_pkg::LEVELS_RESET;
      state_r.pending <= '0;
    end else if (s1_fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && has_reply) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && has_reply) begin
      out_reply_r <= reply_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_reply_byte = out_reply_r;

  // Sequence position stays within the five used positions.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.pos == dpsr_pkg::POS_SELECT || state_r.pos == dpsr_pkg::POS_COMMAND ||
    state_r.pos == dpsr_pkg::POS_ID_HI || state_r.pos == dpsr_pkg::POS_BTN_LO ||
    state_r.pos == dpsr_pkg::POS_BTN_HI)
    else $error("sequence position out of range");

  // Every processed exchange leaves a reply in the output register.
  a_exchange_reply: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_req_r.req_type == dpsr_pkg::REQ_EXCHANGE |=> out_valid_r)
    else $error("exchange produced no reply");

  // Reading the high button byte clears its pending releases.
  a_hi_merge: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_req_r.req_type == dpsr_pkg::REQ_EXCHANGE &&
    state_r.pos == dpsr_pkg::POS_BTN_HI |=> state_r.pending[15:8] == '0)
    else $error("high lane releases not merged");

  // Stall only ever holds back a waiting exchange.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && s1_req_r.req_type == dpsr_pkg::REQ_EXCHANGE &&
    out_valid_r && out_stall)
    else $error("input stalled without cause");

endmodule

`default_nettype wire
